// File: hw/rtl/bxavg_pkg.sv
// ----------------------------------------------------------------------------
// bxavg_pkg
// Shared types and constants for the boxcar average temperature core.
// ----------------------------------------------------------------------------
package bxavg_pkg;

    // default build parameters
    localparam int WINDOW_LENGTH_DEF = 10;
    localparam int SAMPLE_BITS_DEF   = 12;

    // field widths
    localparam int TEMP_W   = 16;
    localparam int PERIOD_W = 16;
    localparam int INC_W    = 10;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;
    localparam logic [INC_W-1:0]    INC_RESET    = 10'd10;

    // scaling: 3.3 V full scale, 10 mV/degC, result in 0.01 degC
    localparam logic [TEMP_W-1:0] CELSIUS_SCALE = 16'd33000;
    localparam logic [TEMP_W-1:0] F_OFFSET      = 16'd3200;

    // C*9/5 as one multiply by ceil(9*2^F_SHIFT/5) and a right shift;
    // exact for every 16-bit C since 2^F_SHIFT > 5*2^16
    localparam int F_MUL     = 9;
    localparam int F_DIV     = 5;
    localparam int F_SHIFT   = 19;
    localparam int F_RECIP_W = 20;
    localparam logic [F_RECIP_W-1:0] F_RECIP =
        F_RECIP_W'((F_MUL * (1 << F_SHIFT) + F_DIV - 1) / F_DIV);

    typedef enum logic [0:0] {
        REG_PERIOD = 1'b0,
        REG_INC    = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [INC_W-1:0]    inc;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MULC,
        ST_DIVC,
        ST_MULF,
        ST_ADDF,
        ST_DONE
    } t_state;

endpackage

// File: hw/rtl/bxavg_ram.sv
// ----------------------------------------------------------------------------
// bxavg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bxavg_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 10,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/bxavg_div.sv
// ----------------------------------------------------------------------------
// bxavg_div
// Shared multiplier. Divisions by constants run through it as a multiply by
// a precomputed reciprocal; the caller takes the quotient from the upper bits.
// ----------------------------------------------------------------------------
module bxavg_div #(
    parameter int AW = 19,
    parameter int BW = 20
) (
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic [AW+BW-1:0] o_prod
);

    assign o_prod = (AW+BW)'(i_a) * (AW+BW)'(i_b);

endmodule

// File: hw/rtl/bxavg_regs.sv
// ----------------------------------------------------------------------------
// bxavg_regs
// APB-style configuration registers: sample period and tick increment.
// ----------------------------------------------------------------------------
module bxavg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bxavg_pkg::PADDR_W-1:0]  paddr,
    input  logic [bxavg_pkg::PDATA_W-1:0]  pwdata,
    output logic [bxavg_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready,
    output bxavg_pkg::t_cfg                o_cfg
);

    bxavg_pkg::t_cfg   r_cfg, n_cfg;
    bxavg_pkg::t_reg_idx idx;

    // word address; byte offset bits ignored
    assign idx = bxavg_pkg::t_reg_idx'(paddr[2]);

    always_comb begin
        n_cfg = r_cfg;
        if (psel && penable && pwrite) begin
            unique case (idx)
                bxavg_pkg::REG_PERIOD: n_cfg.period = pwdata[bxavg_pkg::PERIOD_W-1:0];
                bxavg_pkg::REG_INC:    n_cfg.inc    = pwdata[bxavg_pkg::INC_W-1:0];
                default:               n_cfg        = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            bxavg_pkg::REG_PERIOD: prdata = bxavg_pkg::PDATA_W'(r_cfg.period);
            bxavg_pkg::REG_INC:    prdata = bxavg_pkg::PDATA_W'(r_cfg.inc);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period <= bxavg_pkg::PERIOD_RESET;
            r_cfg.inc    <= bxavg_pkg::INC_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

endmodule

// File: hw/rtl/boxcar_average_temperature_core.sv
// ----------------------------------------------------------------------------
// boxcar_average_temperature_core
// Moving-average temperature filter on converter samples, with Celsius and
// Fahrenheit outputs in hundredths of a degree.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall): one transaction per system tick,
//   carrying the current converter sample. Output channel (o_out_valid /
//   i_out_stall): exactly one transaction per input tick with both
//   temperatures and an update flag.
//   Ticks that take no sample, or take one while the window is still filling,
//   go from IDLE straight to DONE, whose hand-over registers the result; the
//   next tick is taken once the core is back in IDLE.
//   Ticks that produce a new temperature step through READ (window RAM read),
//   three passes through one shared multiplier (MULC sum*33000, DIVC the
//   reciprocal of the window length, MULF the 9/5 reciprocal), ADDF (the
//   Fahrenheit offset add) and DONE, whose hand-over registers the result.
//   o_in_stall is high while a tick is in work.
//   The output register decouples the sides: a stalled result holds, the
//   next tick is still accepted, and the core waits at the end of that tick
//   until the register is free. Reset (synchronous, active low) clears the
//   time accumulator, fill count, window pointer and running sum; temperature
//   reads 0 (3200 in Fahrenheit) until the window has filled. Config registers
//   return to 100 ms / 10 ms. Config must be written by the user through the
//   APB port only while the core is idle; the core does not enforce this.
// ----------------------------------------------------------------------------
module boxcar_average_temperature_core #(
    parameter int WINDOW_LENGTH = bxavg_pkg::WINDOW_LENGTH_DEF,
    parameter int SAMPLE_BITS   = bxavg_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [SAMPLE_BITS-1:0]         i_adc_sample,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [bxavg_pkg::TEMP_W-1:0]   o_celsius_centi,
    output logic [bxavg_pkg::TEMP_W-1:0]   o_fahrenheit_centi,
    output logic                           o_updated,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bxavg_pkg::PADDR_W-1:0]  paddr,
    input  logic [bxavg_pkg::PDATA_W-1:0]  pwdata,
    output logic [bxavg_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready
);

    localparam int TW   = bxavg_pkg::TEMP_W;
    localparam int PW_  = bxavg_pkg::PERIOD_W;
    // window address, fill count, running sum
    localparam int AW   = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    localparam int FW   = $clog2(WINDOW_LENGTH + 1);
    localparam int LW   = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 0;
    localparam int SUMW = SAMPLE_BITS + LW;
    // (sum*33000) >> SAMPLE_BITS stays below WINDOW_LENGTH*33000
    localparam int YW   = $clog2(WINDOW_LENGTH * int'(bxavg_pkg::CELSIUS_SCALE));
    // y / N as (y * ceil(2^RN_SH / N)) >> RN_SH, exact for every YW-bit y
    localparam int RN_SH = YW + LW;
    localparam int RNW   = YW + 1;
    localparam longint unsigned RN_VAL =
        ((64'd1 << RN_SH) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
    localparam logic [RNW-1:0] RN_MUL = RNW'(RN_VAL);
    // shared multiplier operands / product
    localparam int MAW0 = (SUMW > YW) ? SUMW : YW;
    localparam int MAW  = (MAW0 > TW) ? MAW0 : TW;
    localparam int MBW0 = (RNW > TW) ? RNW : TW;
    localparam int MBW  = (MBW0 > bxavg_pkg::F_RECIP_W) ? MBW0 : bxavg_pkg::F_RECIP_W;
    localparam int PRW  = MAW + MBW;

    bxavg_pkg::t_cfg   cfg;
    bxavg_pkg::t_state r_state, n_state;

    logic [PW_-1:0]         r_elapsed, n_elapsed;
    logic [FW-1:0]          r_fill, n_fill;
    logic [AW-1:0]          r_ptr, n_ptr;
    logic [SUMW-1:0]        r_sum, n_sum;
    logic [TW-1:0]          r_celsius, n_celsius;   // temperature register
    logic [TW-1:0]          r_fahr, n_fahr;
    logic [SAMPLE_BITS-1:0] r_sample, n_sample;
    logic                   r_upd, n_upd;
    logic [PRW-1:0]         r_prod, n_prod;

    logic                   r_ovalid, n_ovalid;
    logic [TW-1:0]          r_ocel, n_ocel;
    logic [TW-1:0]          r_ofahr, n_ofahr;
    logic                   r_oupd, n_oupd;

    logic                   accept;
    logic [PW_:0]           total;
    logic                   take;
    logic                   full;
    logic [MAW-1:0]         mul_a;
    logic [MBW-1:0]         mul_b;
    logic [PRW-1:0]         mul_p;
    logic [TW-1:0]          cel_q;

    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_waddr;
    logic [SAMPLE_BITS-1:0] ram_wdata, ram_rdata;

    bxavg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bxavg_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_LENGTH),
        .AW    (AW)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    bxavg_div #(
        .AW (MAW),
        .BW (MBW)
    ) u_mul (
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_p)
    );

    assign o_in_stall = (r_state != bxavg_pkg::ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    // time accumulator: sample when elapsed + increment reaches the period
    assign total = {1'b0, r_elapsed} + (PW_ + 1)'(cfg.inc);
    assign take  = (total >= {1'b0, cfg.period});
    assign full  = (r_fill == FW'(WINDOW_LENGTH));

    // window RAM: fill writes at accept, replacement writes in READ
    assign ram_re    = accept && take && full;
    assign ram_we    = (accept && take && !full) || (r_state == bxavg_pkg::ST_READ);
    assign ram_waddr = (r_state == bxavg_pkg::ST_READ) ? r_ptr : r_fill[AW-1:0];
    assign ram_wdata = (r_state == bxavg_pkg::ST_READ) ? r_sample : i_adc_sample;

    // Celsius quotient, valid in MULF
    assign cel_q = TW'(r_prod >> RN_SH);

    // shared multiplier: sum*33000, then /N by reciprocal, then C*9/5
    assign mul_a = (r_state == bxavg_pkg::ST_DIVC) ? MAW'(r_prod >> SAMPLE_BITS) :
                   (r_state == bxavg_pkg::ST_MULF) ? MAW'(cel_q) : MAW'(r_sum);
    assign mul_b = (r_state == bxavg_pkg::ST_DIVC) ? MBW'(RN_MUL) :
                   (r_state == bxavg_pkg::ST_MULF) ? MBW'(bxavg_pkg::F_RECIP) :
                                                     MBW'(bxavg_pkg::CELSIUS_SCALE);

    always_comb begin
        n_state   = r_state;
        n_elapsed = r_elapsed;
        n_fill    = r_fill;
        n_ptr     = r_ptr;
        n_sum     = r_sum;
        n_celsius = r_celsius;
        n_fahr    = r_fahr;
        n_sample  = r_sample;
        n_upd     = r_upd;
        n_prod    = r_prod;
        n_ovalid  = r_ovalid && i_out_stall;
        n_ocel    = r_ocel;
        n_ofahr   = r_ofahr;
        n_oupd    = r_oupd;

        unique case (r_state)
            bxavg_pkg::ST_IDLE: begin
                if (accept) begin
                    n_sample = i_adc_sample;
                    n_upd    = 1'b0;
                    n_state  = bxavg_pkg::ST_DONE;
                    if (take) begin
                        n_elapsed = '0;
                        if (full) begin
                            n_state = bxavg_pkg::ST_READ;
                        end else begin
                            n_sum  = r_sum + SUMW'(i_adc_sample);
                            n_fill = r_fill + 1'b1;
                        end
                    end else begin
                        n_elapsed = total[PW_-1:0];
                    end
                end
            end
            bxavg_pkg::ST_READ: begin
                // oldest entry out, new sample in
                n_sum   = r_sum - SUMW'(ram_rdata) + SUMW'(r_sample);
                n_ptr   = (r_ptr == AW'(WINDOW_LENGTH - 1)) ? '0 : r_ptr + 1'b1;
                n_state = bxavg_pkg::ST_MULC;
            end
            bxavg_pkg::ST_MULC: begin
                n_prod  = mul_p;
                n_state = bxavg_pkg::ST_DIVC;
            end
            bxavg_pkg::ST_DIVC: begin
                n_prod  = mul_p;
                n_state = bxavg_pkg::ST_MULF;
            end
            bxavg_pkg::ST_MULF: begin
                n_celsius = cel_q;
                n_prod    = mul_p;
                n_state   = bxavg_pkg::ST_ADDF;
            end
            bxavg_pkg::ST_ADDF: begin
                n_fahr  = TW'(r_prod >> bxavg_pkg::F_SHIFT) + bxavg_pkg::F_OFFSET;
                n_upd   = 1'b1;
                n_state = bxavg_pkg::ST_DONE;
            end
            bxavg_pkg::ST_DONE: begin
                // hand the result over once the output register is free
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid = 1'b1;
                    n_ocel   = r_celsius;
                    n_ofahr  = r_fahr;
                    n_oupd   = r_upd;
                    n_state  = bxavg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bxavg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bxavg_pkg::ST_IDLE;
            r_elapsed <= '0;
            r_fill    <= '0;
            r_ptr     <= '0;
            r_sum     <= '0;
            r_celsius <= '0;
            r_fahr    <= bxavg_pkg::F_OFFSET;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_elapsed <= n_elapsed;
            r_fill    <= n_fill;
            r_ptr     <= n_ptr;
            r_sum     <= n_sum;
            r_celsius <= n_celsius;
            r_fahr    <= n_fahr;
            r_ovalid  <= n_ovalid;
        end
        r_sample <= n_sample;
        r_upd    <= n_upd;
        r_prod   <= n_prod;
        r_ocel   <= n_ocel;
        r_ofahr  <= n_ofahr;
        r_oupd   <= n_oupd;
    end

    assign o_out_valid        = r_ovalid;
    assign o_celsius_centi    = r_ocel;
    assign o_fahrenheit_centi = r_ofahr;
    assign o_updated          = r_oupd;

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for boxcar_average_temperature_core. A short scripted
// sequence (defaults after reset, window fill, full-scale and zero averages)
// is followed by random converter samples under a range of period/increment
// settings, with random gaps on the input and random stalls on the output.
// Every tick's temperatures and update flag are checked against a behavioral
// model of the filter kept inside this bench, or hand-computed script values.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bxavg_pkg::*;

    localparam int WIN     = WINDOW_LENGTH_DEF;
    localparam int ADC_W   = SAMPLE_BITS_DEF;
    localparam int ADC_MAX = (1 << ADC_W) - 1;

    // cycles allowed for the core to settle before a config write
    localparam int SETTLE_CYCLES = 64;
    // cycles with no transaction and no config access before giving up
    localparam int WATCHDOG_LIMIT = 1000;

    // one output transaction
    typedef struct packed {
        logic [TEMP_W-1:0] celsius;
        logic [TEMP_W-1:0] fahrenheit;
        logic              updated;
    } temp_reading_t;

    // one scripted tick; 'typed' rows carry a hand-computed expectation
    typedef struct {
        logic [ADC_W-1:0] adc;
        bit               typed;
        temp_reading_t    want;
    } script_row_t;

    // one random phase: register values, number of ticks, draw-at-run-time flag
    typedef struct {
        logic [PERIOD_W-1:0] period;
        logic [INC_W-1:0]    inc;
        int                  ticks;
        bit                  draw_cfg;
    } phase_t;

    // hand-computed readings
    localparam temp_reading_t COLD     = '{16'd0, 16'd3200, 1'b0};
    // ten samples of 4095: 40950*33000/40960 = 32991, F = 32991*9/5+3200
    localparam temp_reading_t FULL_NEW = '{16'd32991, 16'd62583, 1'b1};
    localparam temp_reading_t ZERO_NEW = '{16'd0, 16'd3200, 1'b1};
    localparam temp_reading_t NO_WANT  = '0;

    // ------------------------------------------------------------------------
    // DUT signals; every input is known from time zero
    // ------------------------------------------------------------------------
    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic                o_in_stall;
    logic [ADC_W-1:0]    i_adc_sample = '0;
    logic                o_out_valid;
    logic                i_out_stall  = 1'b0;
    logic [TEMP_W-1:0]   o_celsius_centi;
    logic [TEMP_W-1:0]   o_fahrenheit_centi;
    logic                o_updated;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [PADDR_W-1:0]  paddr        = '0;
    logic [PDATA_W-1:0]  pwdata       = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    boxcar_average_temperature_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_adc_sample       (i_adc_sample),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_celsius_centi    (o_celsius_centi),
        .o_fahrenheit_centi (o_fahrenheit_centi),
        .o_updated          (o_updated),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Filter model state: config shadow plus the core's internal state
    // ------------------------------------------------------------------------
    logic [PERIOD_W-1:0] period_ms  = PERIOD_RESET;
    logic [INC_W-1:0]    inc_ms     = INC_RESET;
    logic [PERIOD_W-1:0] elapsed_ms = '0;
    int unsigned         fill_cnt   = 0;
    logic [ADC_W-1:0]    window_mem [WIN];
    int unsigned         oldest_idx = 0;
    int unsigned         window_sum = 0;
    logic [TEMP_W-1:0]   avg_celsius = '0;

    // readings the core still owes, oldest first
    temp_reading_t expected_readings [$];

    // tag that travels with the payload on the input channel
    bit                  drv_typed = 1'b0;
    temp_reading_t       drv_want  = '0;

    // idling control
    bit                  no_idle    = 1'b0;
    int                  stall_left = 0;
    int                  fail_count = 0;
    int                  quiet_cycles = 0;

    // Advance the model by one tick and return the reading it yields.
    function automatic temp_reading_t filter_tick(logic [ADC_W-1:0] adc);
        int unsigned     total;
        longint unsigned scaled;
        temp_reading_t   rd;
        total      = int'(elapsed_ms) + int'(inc_ms);
        rd.updated = 1'b0;
        if (total >= period_ms) begin
            if (fill_cnt < WIN) begin
                // still filling: window and sum move, the average stays
                window_mem[fill_cnt] = adc;
                window_sum += adc;
                fill_cnt++;
            end else begin
                // replace the oldest sample and rescale
                window_sum = window_sum - window_mem[oldest_idx] + adc;
                window_mem[oldest_idx] = adc;
                oldest_idx = (oldest_idx + 1 >= WIN) ? 0 : oldest_idx + 1;
                scaled = (longint'(window_sum) * 33000) / (longint'(WIN) << ADC_W);
                avg_celsius = scaled[TEMP_W-1:0];
                rd.updated  = 1'b1;
            end
            elapsed_ms = '0;
        end else begin
            elapsed_ms = total[PERIOD_W-1:0];
        end
        rd.celsius    = avg_celsius;
        rd.fahrenheit = TEMP_W'((int'(avg_celsius) * 9) / 5 + 3200);
        return rd;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: compare output transactions, record input transactions
    // ------------------------------------------------------------------------
    temp_reading_t seen_want;
    temp_reading_t seen_model;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_readings.size() == 0) begin
                    $error("unexpected reading: C=%0d F=%0d upd=%0b",
                           o_celsius_centi, o_fahrenheit_centi, o_updated);
                    fail_count++;
                end else begin
                    seen_want = expected_readings.pop_front();
                    if (o_celsius_centi !== seen_want.celsius) begin
                        $error("celsius_centi: expected %0d, got %0d",
                               seen_want.celsius, o_celsius_centi);
                        fail_count++;
                    end
                    if (o_fahrenheit_centi !== seen_want.fahrenheit) begin
                        $error("fahrenheit_centi: expected %0d, got %0d",
                               seen_want.fahrenheit, o_fahrenheit_centi);
                        fail_count++;
                    end
                    if (o_updated !== seen_want.updated) begin
                        $error("updated: expected %0b, got %0b",
                               seen_want.updated, o_updated);
                        fail_count++;
                    end
                end
                // stall budget for the next reading
                stall_left = no_idle ? 0 : $urandom_range(0, 8);
            end
            if (i_in_valid && !o_in_stall) begin
                // model always advances; typed scripted rows override its answer
                seen_model = filter_tick(i_adc_sample);
                expected_readings.push_back(drv_typed ? drv_want : seen_model);
            end
        end
    end

    // Output stall: hold off a pending reading while its drawn stall budget lasts.
    always @(negedge i_clk) begin
        if (o_out_valid && stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Watchdog: any transaction or config access restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (i_in_valid && !o_in_stall) ||
            (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else if (++quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** boxcar_average_temperature_core: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Present one tick after a random gap and hold it until accepted.
    task automatic send_tick(logic [ADC_W-1:0] adc, bit typed, temp_reading_t want);
        int gap;
        @(negedge i_clk);
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_adc_sample <= adc;
        drv_typed    <= typed;
        drv_want     <= want;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
    endtask

    // Stop sending, let every owed reading arrive, then let the core settle.
    task automatic wait_filter_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_readings.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // APB write followed by a read-back of the same register.
    task automatic write_cfg_reg(t_reg_idx idx, logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] readback;
        logic [PDATA_W-1:0] stored;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(int'(idx) * 4);
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_PERIOD) begin
            period_ms = value[PERIOD_W-1:0];
            stored    = PDATA_W'(period_ms);
        end else begin
            inc_ms = value[INC_W-1:0];
            stored = PDATA_W'(inc_ms);
        end
        if (readback !== stored) begin
            $error("prdata(%s): expected %0d, got %0d", idx.name(), stored, readback);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Scripted ticks. Rows 0-2 run on reset config (no sample is due yet);
    // the period is then set to zero so every tick takes a sample: ten
    // full-scale samples fill the window, the eleventh gives the top reading,
    // and ten zeros walk the average back down to zero.
    // ------------------------------------------------------------------------
    localparam int SCRIPT_LEN   = 24;
    localparam int PERIOD0_ROW  = 3;

    script_row_t script [SCRIPT_LEN] = '{
        '{12'd4095, 1'b1, COLD},     // reset config, no sample due
        '{12'd0,    1'b1, COLD},
        '{12'd2730, 1'b1, COLD},
        '{12'd4095, 1'b1, COLD},     // period 0: filling starts
        '{12'd4095, 1'b1, COLD},
        '{12'd4095, 1'b1, COLD},
        '{12'd4095, 1'b1, COLD},
        '{12'd4095, 1'b1, COLD},
        '{12'd4095, 1'b1, COLD},
        '{12'd4095, 1'b1, COLD},
        '{12'd4095, 1'b1, COLD},
        '{12'd4095, 1'b1, COLD},
        '{12'd4095, 1'b1, COLD},     // window now full
        '{12'd4095, 1'b1, FULL_NEW}, // first new temperature, full scale
        '{12'd0,    1'b0, NO_WANT},  // zeros replace the oldest entries
        '{12'd0,    1'b0, NO_WANT},
        '{12'd0,    1'b0, NO_WANT},
        '{12'd0,    1'b0, NO_WANT},
        '{12'd0,    1'b0, NO_WANT},
        '{12'd0,    1'b0, NO_WANT},
        '{12'd0,    1'b0, NO_WANT},
        '{12'd0,    1'b0, NO_WANT},
        '{12'd0,    1'b0, NO_WANT},
        '{12'd0,    1'b1, ZERO_NEW}  // all zeros again
    };

    // Random phases; the extremes of both registers appear, including the
    // zero period (sample every tick) and zero increment (time frozen).
    localparam int NUM_PHASES = 9;

    phase_t phases [NUM_PHASES] = '{
        '{16'd1,     10'd1,    250, 1'b0},  // sample every tick
        '{16'd0,     10'd0,    150, 1'b0},  // zero period, zero increment
        '{16'd65535, 10'd1023, 140, 1'b0},  // largest values: one in 65 ticks
        '{16'd100,   10'd0,     40, 1'b0},  // frozen time, no samples
        '{16'd3,     10'd1,    150, 1'b0},
        '{16'd50,    10'd7,    120, 1'b0},
        '{16'd0,     10'd0,    150, 1'b1},  // values drawn at run time
        '{16'd65535, 10'd1,     25, 1'b0},  // long period, elapsed builds up
        '{PERIOD_RESET, INC_RESET, 25, 1'b0}
    };

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [ADC_W-1:0] adc;
        int               pick;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // scripted part
        for (int r = 0; r < SCRIPT_LEN; r++) begin
            if (r == PERIOD0_ROW) begin
                wait_filter_idle();
                write_cfg_reg(REG_PERIOD, '0);
            end
            send_tick(script[r].adc, script[r].typed, script[r].want);
        end

        // random part: each phase starts from an idle core
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (phases[p].draw_cfg) begin
                phases[p].period = $urandom_range(1, 20);
                phases[p].inc    = $urandom_range(1, 20);
            end
            wait_filter_idle();
            write_cfg_reg(REG_PERIOD, PDATA_W'(phases[p].period));
            write_cfg_reg(REG_INC, PDATA_W'(phases[p].inc));
            for (int k = 0; k < phases[p].ticks; k++) begin
                // a back-to-back burst at the start of every 50 ticks
                no_idle = (k % 50) < 12;
                pick = $urandom_range(0, 7);
                if (pick == 0)
                    adc = '0;
                else if (pick == 1)
                    adc = ADC_W'(ADC_MAX);
                else
                    adc = ADC_W'($urandom_range(0, ADC_MAX));
                send_tick(adc, 1'b0, NO_WANT);
            end
            no_idle = 1'b0;
        end

        // drain, then give the verdict
        wait_filter_idle();
        if (fail_count == 0) begin
            $display("** boxcar_average_temperature_core: PASSED **");
        end else begin
            $display("** boxcar_average_temperature_core: FAILED **");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/bxavg_pkg.sv
hw/rtl/bxavg_ram.sv
hw/rtl/bxavg_div.sv
hw/rtl/bxavg_regs.sv
hw/rtl/boxcar_average_temperature_core.sv
bench/testbench.sv
